/* rtl/sslm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staged slew lowpass mixer package
// Shared widths, register map, command codes and structures.
// ----------------------------------------------------------------------------
package sslm_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 20;

    localparam int DATA_BITS     = 32;
    localparam int DIFF_BITS     = 33;
    localparam int MUL_A_BITS    = 33;
    localparam int MUL_B_BITS    = 23;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int ACC_BITS      = 58;
    localparam int COEF_REG_BITS = 60;
    localparam int MIX_BITS      = 18;
    localparam int WET_BITS      = 17;
    localparam int APB_ADDR_BITS = 6;
    localparam int APB_DATA_BITS = 64;
    localparam int REG_IDX_BITS  = 3;
    localparam int NUM_UNITS     = 4;
    localparam int UNIT_BITS     = 2;
    localparam int LN10_SHIFT    = 20;
    localparam int WET_SHIFT     = 16;

    localparam logic [REG_IDX_BITS-1:0] REG_STAGE_ONE   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_STAGE_TWO   = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_STAGE_THREE = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FINAL       = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_MIX         = 3'd4;

    localparam logic [UNIT_BITS-1:0] UNIT_ONE   = 2'd0;
    localparam logic [UNIT_BITS-1:0] UNIT_TWO   = 2'd1;
    localparam logic [UNIT_BITS-1:0] UNIT_THREE = 2'd2;
    localparam logic [UNIT_BITS-1:0] UNIT_FINAL = 2'd3;

    localparam logic [MIX_BITS-1:0] MIX_ONE = 18'd65536;
    localparam logic [MIX_BITS-1:0] MIX_TWO = 18'd131072;
    localparam logic [MIX_BITS-1:0] MIX_MAX = 18'd196608;
    localparam logic [WET_BITS-1:0] WET_ONE = 17'd65536;

    localparam logic [COEF_REG_BITS-1:0] COEF_REG_MASK = {COEF_REG_BITS{1'b1}};
    localparam logic [MIX_BITS-1:0]      MIX_REG_MASK  = {MIX_BITS{1'b1}};

    localparam logic signed [MUL_B_BITS-1:0] LN10_Q20 = 23'sd2414435;

    localparam logic [2:0] A_X    = 3'd0;
    localparam logic [2:0] A_X1   = 3'd1;
    localparam logic [2:0] A_X2   = 3'd2;
    localparam logic [2:0] A_Y1   = 3'd3;
    localparam logic [2:0] A_Y2   = 3'd4;
    localparam logic [2:0] A_DIFF = 3'd5;
    localparam logic [2:0] A_WET  = 3'd6;

    localparam logic [2:0] B_B0   = 3'd0;
    localparam logic [2:0] B_A1   = 3'd1;
    localparam logic [2:0] B_A2   = 3'd2;
    localparam logic [2:0] B_LN10 = 3'd3;
    localparam logic [2:0] B_WET  = 3'd4;
    localparam logic [2:0] B_DRY  = 3'd5;

    localparam logic [2:0] ACC_NONE = 3'd0;
    localparam logic [2:0] ACC_LOAD = 3'd1;
    localparam logic [2:0] ACC_ADD  = 3'd2;
    localparam logic [2:0] ACC_ADD2 = 3'd3;
    localparam logic [2:0] ACC_SUB  = 3'd4;

    localparam logic [1:0] FIN_NONE = 2'd0;
    localparam logic [1:0] FIN_Y    = 2'd1;
    localparam logic [1:0] FIN_S    = 2'd2;
    localparam logic [1:0] FIN_X    = 2'd3;

    typedef struct packed {
        logic                 load_in;
        logic                 upd;
        logic                 out_load;
        logic [UNIT_BITS-1:0] unit;
        logic [2:0]           a_sel;
        logic [2:0]           b_sel;
        logic [2:0]           acc_op;
        logic [1:0]           fin_op;
    } cmd_t;

    typedef struct packed {
        logic [NUM_UNITS-1:0] unit_act;
    } sts_t;

    typedef struct packed {
        logic [NUM_UNITS-1:0][COEF_REG_BITS-1:0] coefs;
        logic [MIX_BITS-1:0]                     mix;
    } cfg_t;

    typedef struct packed {
        logic signed [DATA_BITS-1:0] x1;
        logic signed [DATA_BITS-1:0] x2;
        logic signed [DATA_BITS-1:0] y1;
        logic signed [DATA_BITS-1:0] y2;
    } hist_t;

endpackage

/* rtl/sslm_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staged slew lowpass mixer configuration registers
// APB register file holding the four coefficient sets and the mix amount.
// ----------------------------------------------------------------------------
module sslm_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sslm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [sslm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [sslm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output sslm_pkg::cfg_t                      cfg
);
    import sslm_pkg::*;

    logic [NUM_UNITS-1:0][COEF_REG_BITS-1:0] coefs_reg;
    logic [MIX_BITS-1:0]                     mix_reg;
    logic [REG_IDX_BITS-1:0]                 idx;
    logic                                    wr;

    assign idx    = paddr[APB_ADDR_BITS-1:3];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg <= '0;
            mix_reg   <= '0;
        end else if (wr) begin
            case (idx)
                REG_STAGE_ONE:   coefs_reg[UNIT_ONE]   <= pwdata[COEF_REG_BITS-1:0];
                REG_STAGE_TWO:   coefs_reg[UNIT_TWO]   <= pwdata[COEF_REG_BITS-1:0];
                REG_STAGE_THREE: coefs_reg[UNIT_THREE] <= pwdata[COEF_REG_BITS-1:0];
                REG_FINAL:       coefs_reg[UNIT_FINAL] <= pwdata[COEF_REG_BITS-1:0];
                REG_MIX:         mix_reg               <= pwdata[MIX_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_STAGE_ONE:   prdata = APB_DATA_BITS'(coefs_reg[UNIT_ONE]);
            REG_STAGE_TWO:   prdata = APB_DATA_BITS'(coefs_reg[UNIT_TWO]);
            REG_STAGE_THREE: prdata = APB_DATA_BITS'(coefs_reg[UNIT_THREE]);
            REG_FINAL:       prdata = APB_DATA_BITS'(coefs_reg[UNIT_FINAL]);
            REG_MIX:         prdata = APB_DATA_BITS'(mix_reg);
            default:         prdata = '0;
        endcase
    end

    assign cfg.coefs = coefs_reg;
    assign cfg.mix   = mix_reg;

endmodule

/* rtl/sslm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staged slew lowpass mixer controller
// Sequences the filter units through the shared multiply-accumulate datapath.
// ----------------------------------------------------------------------------
module sslm_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    input  sslm_pkg::sts_t sts,
    output sslm_pkg::cmd_t cmd
);
    import sslm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_PUSH = 2'd2;

    localparam logic [3:0] S_MX   = 4'd0;
    localparam logic [3:0] S_MX1  = 4'd1;
    localparam logic [3:0] S_MX2  = 4'd2;
    localparam logic [3:0] S_MY1  = 4'd3;
    localparam logic [3:0] S_MY2  = 4'd4;
    localparam logic [3:0] S_ACCB = 4'd5;
    localparam logic [3:0] S_FINY = 4'd6;
    localparam logic [3:0] S_UPD  = 4'd7;
    localparam logic [3:0] S_MD   = 4'd8;
    localparam logic [3:0] S_ACCD = 4'd9;
    localparam logic [3:0] S_FINS = 4'd10;
    localparam logic [3:0] S_MW   = 4'd11;
    localparam logic [3:0] S_MDRY = 4'd12;
    localparam logic [3:0] S_ACCX = 4'd13;
    localparam logic [3:0] S_FINX = 4'd14;

    logic [1:0]           state_reg, state_next;
    logic [3:0]           step_reg, step_next;
    logic [UNIT_BITS-1:0] unit_reg, unit_next;
    logic                 m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= S_MX;
            unit_reg    <= UNIT_ONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            unit_reg    <= unit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        unit_next    = unit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.unit     = unit_reg;
        s_ready      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    unit_next   = UNIT_ONE;
                    step_next   = S_MX;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_reg == S_MX && !sts.unit_act[unit_reg]) begin
                    if (unit_reg == UNIT_FINAL) begin
                        state_next = ST_PUSH;
                    end else begin
                        unit_next = unit_reg + 1'b1;
                    end
                end else begin
                    step_next = step_reg + 1'b1;
                    case (step_reg)
                        S_MX: begin
                            cmd.a_sel = A_X;
                            cmd.b_sel = B_B0;
                        end
                        S_MX1: begin
                            cmd.a_sel  = A_X1;
                            cmd.b_sel  = B_B0;
                            cmd.acc_op = ACC_LOAD;
                        end
                        S_MX2: begin
                            cmd.a_sel  = A_X2;
                            cmd.b_sel  = B_B0;
                            cmd.acc_op = ACC_ADD2;
                        end
                        S_MY1: begin
                            cmd.a_sel  = A_Y1;
                            cmd.b_sel  = B_A1;
                            cmd.acc_op = ACC_ADD;
                        end
                        S_MY2: begin
                            cmd.a_sel  = A_Y2;
                            cmd.b_sel  = B_A2;
                            cmd.acc_op = ACC_SUB;
                        end
                        S_ACCB: cmd.acc_op = ACC_SUB;
                        S_FINY: cmd.fin_op = FIN_Y;
                        S_UPD: begin
                            cmd.upd = 1'b1;
                            if (unit_reg == UNIT_FINAL) begin
                                step_next = S_MW;
                            end
                        end
                        S_MD: begin
                            cmd.a_sel = A_DIFF;
                            cmd.b_sel = B_LN10;
                        end
                        S_ACCD: cmd.acc_op = ACC_LOAD;
                        S_FINS: cmd.fin_op = FIN_S;
                        S_MW: begin
                            cmd.a_sel = A_WET;
                            cmd.b_sel = B_WET;
                        end
                        S_MDRY: begin
                            cmd.a_sel  = A_X;
                            cmd.b_sel  = B_DRY;
                            cmd.acc_op = ACC_LOAD;
                        end
                        S_ACCX: cmd.acc_op = ACC_ADD;
                        S_FINX: begin
                            cmd.fin_op = FIN_X;
                            step_next  = S_MX;
                            if (unit_reg == UNIT_FINAL) begin
                                state_next = ST_PUSH;
                            end else begin
                                unit_next = unit_reg + 1'b1;
                            end
                        end
                        default: step_next = S_MX;
                    endcase
                end
            end
            ST_PUSH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

/* rtl/sslm_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staged slew lowpass mixer datapath
// Shared multiplier, accumulator, rounding and saturation, filter state.
// ----------------------------------------------------------------------------
module sslm_dp #(
    parameter int SAMPLE_BITS = sslm_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sslm_pkg::COEF_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sslm_pkg::cmd_t                cmd,
    input  sslm_pkg::cfg_t                cfg,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic signed [SAMPLE_BITS-1:0] m_sample_out,
    output sslm_pkg::sts_t                sts
);
    import sslm_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ACC_ONE  = {{(ACC_BITS-1){1'b0}}, 1'b1};
    localparam logic signed [ACC_BITS-1:0] ACC_DMAX =
        {{(ACC_BITS-DATA_BITS+1){1'b0}}, {(DATA_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_DMIN = ~ACC_DMAX;
    localparam logic signed [DATA_BITS-1:0] OUT_MAX =
        {{(DATA_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [DATA_BITS-1:0] OUT_MIN = ~OUT_MAX;

    logic signed [DATA_BITS-1:0]   x_reg, y_reg, w_reg;
    logic signed [DIFF_BITS-1:0]   diff_reg;
    logic signed [PROD_BITS-1:0]   p_reg;
    logic signed [ACC_BITS-1:0]    acc_reg;
    logic signed [SAMPLE_BITS-1:0] out_reg;
    hist_t                         hist_reg [NUM_UNITS];
    logic signed [DATA_BITS-1:0]   prev_reg [3];

    logic [MIX_BITS-1:0]           mix_c;
    logic [WET_BITS-1:0]           wa, wb, wc, wet, dry;
    logic [COEF_REG_BITS-1:0]      coef;
    logic signed [MUL_B_BITS-1:0]  b0, a1, a2;
    hist_t                         hist;
    logic signed [DATA_BITS-1:0]   prev;
    logic signed [MUL_A_BITS-1:0]  a_op;
    logic signed [MUL_B_BITS-1:0]  b_op;
    logic signed [ACC_BITS-1:0]    p_ext, half, rnd, sh;
    logic signed [DATA_BITS-1:0]   fin_val;

    always_comb begin
        mix_c = (cfg.mix > MIX_MAX) ? MIX_MAX : cfg.mix;
        if (mix_c < MIX_ONE) begin
            wa = WET_BITS'(mix_c);
            wb = '0;
            wc = '0;
        end else if (mix_c < MIX_TWO) begin
            wa = WET_ONE;
            wb = WET_BITS'(mix_c - MIX_ONE);
            wc = '0;
        end else begin
            wa = WET_ONE;
            wb = WET_ONE;
            wc = WET_BITS'(mix_c - MIX_TWO);
        end
    end

    always_comb begin
        case (cmd.unit)
            UNIT_ONE:   wet = wa;
            UNIT_TWO:   wet = wb;
            UNIT_THREE: wet = wc;
            default:    wet = wa;
        endcase
        dry = WET_ONE - wet;
    end

    assign sts.unit_act = {(wa != '0), (wc != '0), (wb != '0), (wa != '0)};

    always_comb begin
        coef = cfg.coefs[cmd.unit];
        b0   = MUL_B_BITS'(signed'(coef[COEF_BITS-1:0]));
        a1   = MUL_B_BITS'(signed'(coef[2*COEF_BITS-1:COEF_BITS]));
        a2   = MUL_B_BITS'(signed'(coef[3*COEF_BITS-1:2*COEF_BITS]));
        hist = hist_reg[cmd.unit];
        case (cmd.unit)
            UNIT_ONE:   prev = prev_reg[0];
            UNIT_TWO:   prev = prev_reg[1];
            UNIT_THREE: prev = prev_reg[2];
            default:    prev = '0;
        endcase
    end

    always_comb begin
        case (cmd.a_sel)
            A_X:     a_op = MUL_A_BITS'(x_reg);
            A_X1:    a_op = MUL_A_BITS'(hist.x1);
            A_X2:    a_op = MUL_A_BITS'(hist.x2);
            A_Y1:    a_op = MUL_A_BITS'(hist.y1);
            A_Y2:    a_op = MUL_A_BITS'(hist.y2);
            A_DIFF:  a_op = diff_reg;
            A_WET:   a_op = MUL_A_BITS'(w_reg);
            default: a_op = '0;
        endcase
        case (cmd.b_sel)
            B_B0:    b_op = b0;
            B_A1:    b_op = a1;
            B_A2:    b_op = a2;
            B_LN10:  b_op = LN10_Q20;
            B_WET:   b_op = signed'(MUL_B_BITS'(wet));
            B_DRY:   b_op = signed'(MUL_B_BITS'(dry));
            default: b_op = '0;
        endcase
    end

    always_comb begin
        p_ext = ACC_BITS'(p_reg);
        case (cmd.fin_op)
            FIN_Y:   half = ACC_ONE <<< (COEF_BITS - 4);
            FIN_S:   half = ACC_ONE <<< (LN10_SHIFT - 1);
            default: half = ACC_ONE <<< (WET_SHIFT - 1);
        endcase
        rnd = acc_reg + half;
        case (cmd.fin_op)
            FIN_Y:   sh = rnd >>> (COEF_BITS - 3);
            FIN_S:   sh = rnd >>> LN10_SHIFT;
            default: sh = rnd >>> WET_SHIFT;
        endcase
        if (sh > ACC_DMAX) begin
            fin_val = ACC_DMAX[DATA_BITS-1:0];
        end else if (sh < ACC_DMIN) begin
            fin_val = ACC_DMIN[DATA_BITS-1:0];
        end else begin
            fin_val = sh[DATA_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        p_reg <= a_op * b_op;
        case (cmd.acc_op)
            ACC_LOAD: acc_reg <= p_ext;
            ACC_ADD:  acc_reg <= acc_reg + p_ext;
            ACC_ADD2: acc_reg <= acc_reg + (p_ext <<< 1);
            ACC_SUB:  acc_reg <= acc_reg - p_ext;
            default:  acc_reg <= acc_reg;
        endcase
        if (cmd.load_in) begin
            x_reg <= DATA_BITS'(s_sample_in);
        end
        case (cmd.fin_op)
            FIN_Y:   y_reg <= fin_val;
            FIN_S:   w_reg <= fin_val;
            FIN_X:   x_reg <= fin_val;
            default: ;
        endcase
        if (cmd.upd) begin
            if (cmd.unit == UNIT_FINAL) begin
                w_reg <= y_reg;
            end else begin
                diff_reg <= DIFF_BITS'(y_reg) - DIFF_BITS'(prev);
            end
        end
        if (cmd.out_load) begin
            if (x_reg > OUT_MAX) begin
                out_reg <= OUT_MAX[SAMPLE_BITS-1:0];
            end else if (x_reg < OUT_MIN) begin
                out_reg <= OUT_MIN[SAMPLE_BITS-1:0];
            end else begin
                out_reg <= x_reg[SAMPLE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_UNITS; i++) begin
                hist_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
            end
        end else if (cmd.upd) begin
            hist_reg[cmd.unit].x2 <= hist.x1;
            hist_reg[cmd.unit].x1 <= x_reg;
            hist_reg[cmd.unit].y2 <= hist.y1;
            hist_reg[cmd.unit].y1 <= y_reg;
            case (cmd.unit)
                UNIT_ONE:   prev_reg[0] <= y_reg;
                UNIT_TWO:   prev_reg[1] <= y_reg;
                UNIT_THREE: prev_reg[2] <= y_reg;
                default: ;
            endcase
        end
    end

    assign m_sample_out = out_reg;

endmodule

/* rtl/staged_slew_lowpass_mixer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staged slew lowpass mixer
// Up to three slew stages of lowpass biquad, scaled difference and crossfade,
// then a final smoothing lowpass crossfade and saturation to full scale.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Ports                                  | Handshake
//  ---------+-----------+----------------------------------------+-----------
//  input    | in        | s_valid, s_ready, s_sample_in          | valid/ready
//  result   | out       | m_valid, m_ready, m_sample_out         | valid/ready
//  config   | in        | psel, penable, pwrite, paddr, pwdata,  | APB
//           |           | prdata, pready                         |
//
// One shared 33x23 multiplier is used for every product. Each active slew stage
// and then the final smoothing stage runs its multiply-accumulate sequence in
// turn, an inactive stage is skipped, and the result is loaded into the output
// register once the previous result has been taken. The next input transaction
// is taken while a result waits in the output register. Reset is synchronous and clears all filter state.
// ----------------------------------------------------------------------------
module staged_slew_lowpass_mixer #(
    parameter int SAMPLE_BITS = sslm_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = sslm_pkg::COEF_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_sample_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sslm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [sslm_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [sslm_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                pready
);
    import sslm_pkg::*;

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    sslm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sslm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sslm_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg          (cfg),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out),
        .sts          (sts)
    );

endmodule

/* rtl/sslm_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Staged slew lowpass mixer port checker
// Watches the top-level ports for handshake and register behavior.
// ----------------------------------------------------------------------------
module sslm_chk #(
    parameter int SAMPLE_BITS = sslm_pkg::SAMPLE_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic signed [SAMPLE_BITS-1:0]       s_sample_in,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [SAMPLE_BITS-1:0]       m_sample_out,
    input logic                                psel,
    input logic                                penable,
    input logic                                pwrite,
    input logic [sslm_pkg::APB_ADDR_BITS-1:0]  paddr,
    input logic [sslm_pkg::APB_DATA_BITS-1:0]  pwdata,
    input logic [sslm_pkg::APB_DATA_BITS-1:0]  prdata,
    input logic                                pready
);
    import sslm_pkg::*;

    logic [REG_IDX_BITS-1:0] idx;
    assign idx = paddr[APB_ADDR_BITS-1:3];

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input accepted while a transaction was already in progress.");

    a_result_needs_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("Result appeared without a transaction in progress.");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_sample_out))
        else $error("Stalled result changed or was dropped.");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("Register port inserted a wait state.");

    a_mix_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && idx == REG_MIX
        |=> idx != REG_MIX || prdata == (APB_DATA_BITS'(MIX_REG_MASK) & $past(pwdata)))
        else $error("Mix register read back a value other than the one written.");

endmodule

bind staged_slew_lowpass_mixer sslm_chk #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);
